[src/point_to_pixel_projection_macros.svh]
// ----------------------------------------------------------------------------
// point_to_pixel_projection_macros
// assertion macros used by the projection rtl
// ----------------------------------------------------------------------------
`ifndef POINT_TO_PIXEL_PROJECTION_MACROS_SVH
`define POINT_TO_PIXEL_PROJECTION_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define P2P_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define P2P_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/p2p_pkg.sv]
// ----------------------------------------------------------------------------
// p2p_pkg
// shared constants and register codes of the point to pixel projection
// ----------------------------------------------------------------------------
package p2p_pkg;

	// transform entries, signed q4.12
	localparam int ENTRY_W    = 16;
	localparam int COORD_FRAC = 12;

	// focal length and center, unsigned
	localparam int FOCAL_W = 16;

	// output coordinates
	localparam int MAP_W = 16;

	// quotient bits kept; anything at or above 2^17 saturates the output
	localparam int QUO_BITS = 17;

	// width of center +/- quotient before clamping
	localparam int VAL_W = 19;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 19'sd32767;
	localparam logic signed [VAL_W-1:0] VAL_MIN = -19'sd32768;

	// configuration port
	localparam int CFG_ADDR_W   = 6;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_LSB = 3;

	typedef enum logic [2:0] {
		REG_ROW_X    = 3'd0,
		REG_ROW_Y    = 3'd1,
		REG_ROW_Z    = 3'd2,
		REG_FOCAL_X  = 3'd3,
		REG_FOCAL_Y  = 3'd4,
		REG_CENTER_X = 3'd5,
		REG_CENTER_Y = 3'd6
	} cfg_reg_t;

endpackage

[src/p2p_point_if.sv]
// ----------------------------------------------------------------------------
// p2p_point_if
// request channel carrying one root-frame point
// ----------------------------------------------------------------------------
interface p2p_point_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

[src/p2p_pixel_if.sv]
// ----------------------------------------------------------------------------
// p2p_pixel_if
// result channel carrying one source pixel coordinate pair
// ----------------------------------------------------------------------------
interface p2p_pixel_if;
	logic                                valid;
	logic                                ready;
	logic signed [p2p_pkg::MAP_W-1:0]    map_x;
	logic signed [p2p_pkg::MAP_W-1:0]    map_y;
	logic                                in_front;

	modport source (output valid, output map_x, output map_y, output in_front,
		input ready);
	modport sink (input valid, input map_x, input map_y, input in_front,
		output ready);
endinterface

[src/p2p_div.sv]
// ----------------------------------------------------------------------------
// p2p_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
module p2p_div #(
	parameter int NUM_W = 51,
	parameter int DEN_W = 34,
	parameter int QB    = 17,
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic [QB:0]       en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [TAG_W-1:0]  tag,
	output logic [QB-1:0]     quo,
	output logic              ovf,
	output logic [TAG_W-1:0]  tag_out
);

	logic [DEN_W-1:0] rem_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic [QB-1:0]    low_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic             ovf_s [QB+1];
	logic [TAG_W-1:0] tag_s [QB+1];

	// first stage: overflow when the quotient needs more than QB bits
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= num[NUM_W-1:QB];
			low_s[0] <= num[QB-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (num[NUM_W-1:QB] >= den);
			tag_s[0] <= tag;
		end
	end

	// one shift and conditional subtract per stage
	for (genvar j = 1; j <= QB; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[j-1], low_s[j-1][QB-1]};
		assign ge    = (trial >= {1'b0, den_s[j-1]});

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= ge ? DEN_W'(trial - {1'b0, den_s[j-1]}) : trial[DEN_W-1:0];
				low_s[j] <= low_s[j-1] << 1;
				den_s[j] <= den_s[j-1];
				quo_s[j] <= {quo_s[j-1][QB-2:0], ge};
				ovf_s[j] <= ovf_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
		end
	end

	assign quo     = quo_s[QB];
	assign ovf     = ovf_s[QB];
	assign tag_out = tag_s[QB];

endmodule

[src/point_to_pixel_projection.sv]
// ----------------------------------------------------------------------------
// point_to_pixel_projection
// pinhole projection of a root-frame point into source pixel coordinates
// ----------------------------------------------------------------------------
// usage
//   point (sink) takes one signed q4.12 point per request; pixel (source)
//   returns one map_x/map_y pair in q12.4 with an in_front flag per request.
//   the apb port holds the 3x4 transform rows, focal lengths and center;
//   write it only while no request is in flight.
//   there are 24 register stages, and one request enters every cycle unless
//   every stage holds a request and pixel.ready is low. the depth is set by
//   the 17 quotient bits of the restoring divider, one bit per stage, plus 7
//   stages of transform, row sum, magnitude, focal multiply, rounding offset,
//   overflow check and clamp.
//   points on or behind the camera give -1.0 for both coordinates.
//   reset clears all stage valid bits and loads the identity transform,
//   focal 256.0 and center (160.0, 120.0).
//   when pixel.ready is low, full stages hold and bubbles close up; point
//   keeps accepting until every stage holds a request.
// ----------------------------------------------------------------------------
`include "point_to_pixel_projection_macros.svh"

module point_to_pixel_projection #(
	parameter int COORD_WIDTH   = 16,
	parameter int MAP_FRAC_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	p2p_point_if.sink                         point,
	p2p_pixel_if.source                       pixel,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [p2p_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [p2p_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [p2p_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int EW     = p2p_pkg::ENTRY_W;
	localparam int FW     = p2p_pkg::FOCAL_W;
	localparam int QB     = p2p_pkg::QUO_BITS;
	localparam int VW     = p2p_pkg::VAL_W;
	localparam int MW     = p2p_pkg::MAP_W;
	localparam int PROD_W = EW + COORD_WIDTH;
	localparam int CAM_W  = PROD_W + 2;
	localparam int DEN_W  = CAM_W;
	localparam int NUM_W  = CAM_W + FW + 1;
	localparam int DIV_LO = 6;
	localparam int L      = DIV_LO + QB + 1;
	localparam logic signed [MW-1:0] MINUS_ONE = MW'(-(32'sd1 <<< MAP_FRAC_BITS));

	// configuration registers
	logic [p2p_pkg::CFG_DATA_W-1:0] row_q [3];
	logic [FW-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	p2p_pkg::cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = p2p_pkg::cfg_reg_t'(paddr[p2p_pkg::CFG_ADDR_W-1:p2p_pkg::CFG_ADDR_LSB]);

	// apb write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= 64'd4096;
			row_q[1]   <= 64'd268435456;
			row_q[2]   <= 64'd17592186044416;
			focal_x_q  <= 16'd4096;
			focal_y_q  <= 16'd4096;
			center_x_q <= 16'd2560;
			center_y_q <= 16'd1920;
		end else if (psel && penable && pwrite && pready) begin
			unique case (cfg_sel)
				p2p_pkg::REG_ROW_X:    row_q[0]   <= pwdata;
				p2p_pkg::REG_ROW_Y:    row_q[1]   <= pwdata;
				p2p_pkg::REG_ROW_Z:    row_q[2]   <= pwdata;
				p2p_pkg::REG_FOCAL_X:  focal_x_q  <= pwdata[FW-1:0];
				p2p_pkg::REG_FOCAL_Y:  focal_y_q  <= pwdata[FW-1:0];
				p2p_pkg::REG_CENTER_X: center_x_q <= pwdata[FW-1:0];
				p2p_pkg::REG_CENTER_Y: center_y_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	// apb read
	always_comb begin
		unique case (cfg_sel)
			p2p_pkg::REG_ROW_X:    prdata = row_q[0];
			p2p_pkg::REG_ROW_Y:    prdata = row_q[1];
			p2p_pkg::REG_ROW_Z:    prdata = row_q[2];
			p2p_pkg::REG_FOCAL_X:  prdata = p2p_pkg::CFG_DATA_W'(focal_x_q);
			p2p_pkg::REG_FOCAL_Y:  prdata = p2p_pkg::CFG_DATA_W'(focal_y_q);
			p2p_pkg::REG_CENTER_X: prdata = p2p_pkg::CFG_DATA_W'(center_x_q);
			p2p_pkg::REG_CENTER_Y: prdata = p2p_pkg::CFG_DATA_W'(center_y_q);
			default:               prdata = '0;
		endcase
	end

	// stage valids and per-stage enables; a stage moves if pixel.ready is high or it or a later one is free
	logic [L:1] vld_q;
	logic [L:1] en;

	for (genvar k = 1; k <= L; k++) begin : g_en
		assign en[k] = pixel.ready | ~(&vld_q[L:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[L-1:1], point.valid} & en);
		end
	end

	assign point.ready = en[1];

	// stage 1: transform products
	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [PROD_W-1:0]      prod_s1 [3][3];

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= PROD_W'(signed'(row_q[r][EW*c +: EW])) * PROD_W'(pt[c]);
				end
			end
		end
	end

	// stage 2: row sums, depth is the negated third row
	logic signed [CAM_W-1:0] sum [3];
	logic signed [CAM_W-1:0] cx_s2, cy_s2, dz_s2;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = (CAM_W'(prod_s1[r][0]) + CAM_W'(prod_s1[r][1]))
				+ (CAM_W'(prod_s1[r][2])
				+ (CAM_W'(signed'(row_q[r][EW*3 +: EW])) <<< p2p_pkg::COORD_FRAC));
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cx_s2 <= sum[0];
			cy_s2 <= sum[1];
			dz_s2 <= -sum[2];
		end
	end

	// stage 3: sign and magnitude, front test
	logic [CAM_W-1:0] mag_x_s3, mag_y_s3, den_s3;
	logic             neg_x_s3, neg_y_s3, front_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_x_s3 <= cx_s2[CAM_W-1];
			neg_y_s3 <= cy_s2[CAM_W-1];
			mag_x_s3 <= cx_s2[CAM_W-1] ? CAM_W'(-cx_s2) : CAM_W'(cx_s2);
			mag_y_s3 <= cy_s2[CAM_W-1] ? CAM_W'(-cy_s2) : CAM_W'(cy_s2);
			den_s3   <= CAM_W'(dz_s2);
			front_s3 <= (dz_s2 > 0);
		end
	end

	// stage 4: scale by focal length
	logic [CAM_W+FW-1:0] fx_s4, fy_s4;
	logic [DEN_W-1:0]    den_s4;
	logic                neg_x_s4, neg_y_s4, front_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			fx_s4    <= (CAM_W+FW)'(mag_x_s3) * (CAM_W+FW)'(focal_x_q);
			fy_s4    <= (CAM_W+FW)'(mag_y_s3) * (CAM_W+FW)'(focal_y_q);
			den_s4   <= den_s3;
			neg_x_s4 <= neg_x_s3;
			neg_y_s4 <= neg_y_s3;
			front_s4 <= front_s3;
		end
	end

	// stage 5: add half the depth for round to nearest
	logic [NUM_W-1:0] num_x_s5, num_y_s5;
	logic [DEN_W-1:0] den_s5;
	logic             neg_x_s5, neg_y_s5, front_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			num_x_s5 <= NUM_W'(fx_s4) + NUM_W'(den_s4 >> 1);
			num_y_s5 <= NUM_W'(fy_s4) + NUM_W'(den_s4 >> 1);
			den_s5   <= den_s4;
			neg_x_s5 <= neg_x_s4;
			neg_y_s5 <= neg_y_s4;
			front_s5 <= front_s4;
		end
	end

	// dividers, stages 6 .. L-1
	logic [QB-1:0] quo_x, quo_y;
	logic          ovf_x, ovf_y, neg_x_d, neg_y_d, front_d;

	p2p_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB), .TAG_W(2)) u_div_x (
		.clk     (clk),
		.en      (en[DIV_LO +: QB+1]),
		.num     (num_x_s5),
		.den     (den_s5),
		.tag     ({front_s5, neg_x_s5}),
		.quo     (quo_x),
		.ovf     (ovf_x),
		.tag_out ({front_d, neg_x_d})
	);

	p2p_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(QB), .TAG_W(1)) u_div_y (
		.clk     (clk),
		.en      (en[DIV_LO +: QB+1]),
		.num     (num_y_s5),
		.den     (den_s5),
		.tag     (neg_y_s5),
		.quo     (quo_y),
		.ovf     (ovf_y),
		.tag_out (neg_y_d)
	);

	// last stage: apply center, clamp, replace points behind the camera
	function automatic logic signed [MW-1:0] place(
		input logic [QB-1:0] q,
		input logic          ovf,
		input logic          neg,
		input logic [FW-1:0] ctr
	);
		logic signed [VW-1:0] c;
		logic signed [VW-1:0] s;
		logic signed [VW-1:0] v;
		c = signed'(VW'(ctr));
		s = signed'(VW'(q));
		v = neg ? (c - s) : (c + s);
		if (ovf) begin
			v = neg ? p2p_pkg::VAL_MIN : p2p_pkg::VAL_MAX;
		end
		if (v > p2p_pkg::VAL_MAX) begin
			v = p2p_pkg::VAL_MAX;
		end else if (v < p2p_pkg::VAL_MIN) begin
			v = p2p_pkg::VAL_MIN;
		end
		return v[MW-1:0];
	endfunction

	logic signed [MW-1:0] map_x_s24, map_y_s24;
	logic                 front_s24;

	always_ff @(posedge clk) begin
		if (en[L]) begin
			map_x_s24 <= front_d ? place(quo_x, ovf_x, neg_x_d, center_x_q) : MINUS_ONE;
			map_y_s24 <= front_d ? place(quo_y, ovf_y, neg_y_d, center_y_q) : MINUS_ONE;
			front_s24 <= front_d;
		end
	end

	assign pixel.valid    = vld_q[L];
	assign pixel.map_x    = map_x_s24;
	assign pixel.map_y    = map_y_s24;
	assign pixel.in_front = front_s24;

	// checks
	`P2P_ASSERT_IMP(a_behind_value, pixel.valid && !pixel.in_front, pixel.map_x == MINUS_ONE && pixel.map_y == MINUS_ONE, "point behind camera without -1.0 output")
	`P2P_ASSERT_NXT(a_accept_enters, point.valid && point.ready, vld_q[1], "accepted request missing from first stage")
	`P2P_ASSERT_IMP(a_full_stall, (&vld_q) && !pixel.ready, !point.ready, "request accepted into a full stalled pipeline")
	`P2P_ASSERT_IMP(a_bubble_ready, !vld_q[L], point.ready, "pipeline refused a request with an empty output stage")

endmodule
